### rtl/sound_channel_allocator_core_defines.svh
// Assertion macros for the sound channel allocator core.
// Used by the top level; expects clk and rst_n in the enclosing scope.
`ifndef SOUND_CHANNEL_ALLOCATOR_CORE_DEFINES_SVH
`define SOUND_CHANNEL_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define SCA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define SCA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/sca_pkg.sv
// Shared constants, codes and controller/datapath interface types
// for the sound channel allocator. No dependencies.
package sca_pkg;

    // Sizing
    localparam int CHANNELS     = 3;
    localparam int SOUND_SLOTS  = 64;
    localparam int FIXED_SOUNDS = 14;
    localparam int TIME_BITS    = 32;

    localparam int CH_IW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SLOT_AW = $clog2(SOUND_SLOTS);
    localparam int COUNT_W = $clog2(SOUND_SLOTS + 1);

    // Field widths
    localparam int REQ_W    = 2;
    localparam int ID_W     = 10;
    localparam int AMP_W    = 8;
    localparam int PERS_W   = 16;
    localparam int PRIO_W   = 3;
    localparam int STATUS_W = 3;
    localparam int CHAN_W   = 2;
    localparam int SLOT_W   = 6;

    // Stream packing
    localparam int IN_DATA_W  = 40;
    localparam int IN_USER_W  = REQ_W;
    localparam int OUT_DATA_W = 16;
    localparam int OUT_USER_W = STATUS_W;

    localparam int ID_LSB   = 0;
    localparam int AMP_LSB  = ID_LSB + ID_W;
    localparam int PERS_LSB = AMP_LSB + AMP_W;
    localparam int PRIO_LSB = PERS_LSB + PERS_W;

    localparam logic [PRIO_W-1:0] VERY_LOW_PRIORITY = PRIO_W'(1);

    // Request kinds
    typedef enum logic [REQ_W-1:0] {
        REQ_TICK = 2'd0,
        REQ_PLAY = 2'd1,
        REQ_LOAD = 2'd2
    } req_type_t;

    // Result codes
    typedef enum logic [STATUS_W-1:0] {
        ST_TICK       = 3'd0,
        ST_PLAYED     = 3'd1,
        ST_SILENT     = 3'd2,
        ST_NO_CHANNEL = 3'd3,
        ST_NOT_LOADED = 3'd4,
        ST_LOADED     = 3'd5,
        ST_ALREADY    = 3'd6,
        ST_FULL       = 3'd7
    } status_t;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_OLDEST,
        S_PICKED,
        S_LOOKUP,
        S_SCAN,
        S_RESP
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic    capture;
        logic    tick;
        logic    pick_eval;
        logic    old_step;
        logic    scan_start;
        logic    commit;
        logic    append;
        logic    load_result;
        status_t res_status;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        req_type_t req_type;
        logic      amp_zero;
        logic      pick_found;
        logic      old_last;
        logic      pick_valid;
        logic      scan_done;
        logic      scan_hit;
        logic      table_full;
        logic      out_stall;
    } stat_t;

endpackage

### rtl/sca_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module sca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/sca_ctrl.sv
// Sequencing state machine of the sound channel allocator.
// Depends on sca_pkg; drives the datapath through cmd_t, watches stat_t.
module sca_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  sca_pkg::stat_t stat,
    output sca_pkg::cmd_t  cmd
);

    import sca_pkg::*;

    state_t  state_reg, state_next;
    status_t code_reg, code_next;

    // State and pending result code
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            code_reg  <= ST_TICK;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        code_next      = code_reg;
        cmd            = '0;
        cmd.res_status = code_reg;
        in_ready       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end

            S_DECODE:
            begin
                unique case (stat.req_type)
                    REQ_TICK:
                    begin
                        cmd.tick   = 1'b1;
                        code_next  = ST_TICK;
                        state_next = S_RESP;
                    end
                    REQ_PLAY:
                    begin
                        if (stat.amp_zero)
                        begin
                            code_next  = ST_SILENT;
                            state_next = S_RESP;
                        end
                        else
                        begin
                            cmd.pick_eval = 1'b1;
                            state_next    = stat.pick_found ? S_LOOKUP : S_OLDEST;
                        end
                    end
                    REQ_LOAD:
                    begin
                        state_next = S_LOOKUP;
                    end
                    default:
                    begin
                        // unused request kind: no state change
                        code_next  = ST_TICK;
                        state_next = S_RESP;
                    end
                endcase
            end

            S_OLDEST:
            begin
                cmd.old_step = 1'b1;
                if (stat.old_last)
                begin
                    state_next = S_PICKED;
                end
            end

            S_PICKED:
            begin
                if (stat.pick_valid)
                begin
                    state_next = S_LOOKUP;
                end
                else
                begin
                    code_next  = ST_NO_CHANNEL;
                    state_next = S_RESP;
                end
            end

            S_LOOKUP:
            begin
                cmd.scan_start = 1'b1;
                state_next     = S_SCAN;
            end

            S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = S_RESP;
                    if (stat.req_type == REQ_PLAY)
                    begin
                        if (stat.scan_hit)
                        begin
                            cmd.commit = 1'b1;
                            code_next  = ST_PLAYED;
                        end
                        else
                        begin
                            code_next = ST_NOT_LOADED;
                        end
                    end
                    else if (stat.scan_hit)
                    begin
                        code_next = ST_ALREADY;
                    end
                    else if (stat.table_full)
                    begin
                        code_next = ST_FULL;
                    end
                    else
                    begin
                        cmd.append = 1'b1;
                        code_next  = ST_LOADED;
                    end
                end
            end

            S_RESP:
            begin
                if (!stat.out_stall)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/sca_datapath.sv
// Datapath of the sound channel allocator: request capture, channel state,
// channel pick, loaded-table scan and output register.
// Depends on sca_pkg and sca_ram.
module sca_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [sca_pkg::IN_DATA_W-1:0]      in_data,
    input  logic [sca_pkg::IN_USER_W-1:0]      in_user,
    input  sca_pkg::cmd_t                      cmd,
    output sca_pkg::stat_t                     stat,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [sca_pkg::OUT_DATA_W-1:0]     out_data,
    output logic [sca_pkg::OUT_USER_W-1:0]     out_user
);

    import sca_pkg::*;

    localparam logic [ID_W:0]    FIXED_ID    = (ID_W + 1)'(FIXED_SOUNDS);
    localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(SOUND_SLOTS);
    localparam logic [COUNT_W-1:0] COUNT_INIT = COUNT_W'(FIXED_SOUNDS);

    // Captured request
    logic [REQ_W-1:0]  req_type_reg;
    logic [ID_W-1:0]   id_reg;
    logic [AMP_W-1:0]  amp_reg;
    logic [PERS_W-1:0] pers_reg;
    logic [PRIO_W-1:0] prio_reg;

    // Time and channel state
    logic [TIME_BITS-1:0] time_reg;
    logic [ID_W-1:0]      chan_sound_reg [CHANNELS];
    logic                 chan_busy_reg  [CHANNELS];
    logic [AMP_W-1:0]     chan_vol_reg   [CHANNELS];
    logic [PRIO_W-1:0]    chan_prio_reg  [CHANNELS];
    logic [TIME_BITS-1:0] chan_ru_reg    [CHANNELS];

    // Channel pick
    logic [CH_IW-1:0]     pick_idx_reg, pick_idx_next;
    logic                 pick_valid_reg, pick_valid_next;
    logic [CH_IW-1:0]     oc_reg, oc_next;
    logic [TIME_BITS-1:0] best_reg, best_next;
    logic                 first_found;
    logic [CH_IW-1:0]     first_idx;
    logic [TIME_BITS-1:0] past;

    // Table scan
    logic               scanning_reg, scanning_next;
    logic [COUNT_W-1:0] rd_addr_reg, rd_addr_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [SLOT_AW-1:0] pend_slot_reg, pend_slot_next;
    logic               scan_done_reg, scan_done_next;
    logic               scan_hit_reg, scan_hit_next;
    logic [SLOT_AW-1:0] slot_reg, slot_next;
    logic [COUNT_W-1:0] count_reg;
    logic [ID_W-1:0]    ram_rdata;
    logic               issue;
    logic               match;

    // Output register
    logic                  out_valid_reg;
    logic [STATUS_W-1:0]   out_status_reg;
    logic [CHAN_W-1:0]     out_chan_reg;
    logic [SLOT_W-1:0]     out_slot_reg;
    logic [AMP_W-1:0]      out_vol_reg;
    logic                  res_played;
    logic                  res_has_slot;

    // Request capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_type_reg <= in_user;
            id_reg       <= in_data[ID_LSB +: ID_W];
            amp_reg      <= in_data[AMP_LSB +: AMP_W];
            pers_reg     <= in_data[PERS_LSB +: PERS_W];
            prio_reg     <= in_data[PRIO_LSB +: PRIO_W];
        end
    end

    // Time counter and channel state updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                chan_sound_reg[i] <= '0;
                chan_busy_reg[i]  <= 1'b0;
                chan_vol_reg[i]   <= '0;
                chan_prio_reg[i]  <= '0;
                chan_ru_reg[i]    <= '0;
            end
        end
        else
        begin
            if (cmd.tick)
            begin
                time_reg <= time_reg + TIME_BITS'(1);
            end
            for (int i = 0; i < CHANNELS; i++)
            begin
                if (cmd.commit && pick_idx_reg == CH_IW'(i))
                begin
                    chan_sound_reg[i] <= id_reg;
                    chan_busy_reg[i]  <= 1'b1;
                    chan_vol_reg[i]   <= amp_reg;
                    chan_prio_reg[i]  <= prio_reg;
                    chan_ru_reg[i]    <= time_reg + TIME_BITS'(pers_reg);
                end
            end
        end
    end

    // First three pick steps: same sound, quieter, lower priority
    always_comb
    begin
        logic           same_found, quiet_found, low_found;
        logic [CH_IW-1:0] same_idx, quiet_idx, low_idx;
        same_found  = 1'b0;
        quiet_found = 1'b0;
        low_found   = 1'b0;
        same_idx    = '0;
        quiet_idx   = '0;
        low_idx     = '0;
        for (int i = CHANNELS - 1; i >= 0; i--)
        begin
            if (chan_busy_reg[i] && chan_sound_reg[i] == id_reg && chan_vol_reg[i] <= amp_reg)
            begin
                same_found = 1'b1;
                same_idx   = CH_IW'(i);
            end
            if (chan_vol_reg[i] < amp_reg)
            begin
                quiet_found = 1'b1;
                quiet_idx   = CH_IW'(i);
            end
            if (chan_prio_reg[i] < prio_reg)
            begin
                low_found = 1'b1;
                low_idx   = CH_IW'(i);
            end
        end
        if (prio_reg > VERY_LOW_PRIORITY && same_found)
        begin
            first_found = 1'b1;
            first_idx   = same_idx;
        end
        else if (quiet_found)
        begin
            first_found = 1'b1;
            first_idx   = quiet_idx;
        end
        else
        begin
            first_found = low_found;
            first_idx   = low_idx;
        end
    end

    // Oldest step: one channel per cycle, signed distance past reservation
    assign past = time_reg - chan_ru_reg[oc_reg];

    always_comb
    begin
        pick_idx_next   = pick_idx_reg;
        pick_valid_next = pick_valid_reg;
        oc_next         = oc_reg;
        best_next       = best_reg;
        if (cmd.pick_eval)
        begin
            pick_idx_next   = first_idx;
            pick_valid_next = first_found;
            oc_next         = '0;
            best_next       = '0;
        end
        else if (cmd.old_step)
        begin
            if (!past[TIME_BITS-1] && past > best_reg)
            begin
                best_next       = past;
                pick_idx_next   = oc_reg;
                pick_valid_next = 1'b1;
            end
            oc_next = oc_reg + CH_IW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pick_valid_reg <= 1'b0;
            pick_idx_reg   <= '0;
            oc_reg         <= '0;
        end
        else
        begin
            pick_valid_reg <= pick_valid_next;
            pick_idx_reg   <= pick_idx_next;
            oc_reg         <= oc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
    end

    // Loaded table: fixed ids live implicitly in the low slots, appended ids in RAM
    sca_ram #(
        .WIDTH (ID_W),
        .DEPTH (SOUND_SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (cmd.append),
        .waddr (count_reg[SLOT_AW-1:0]),
        .wdata (id_reg),
        .raddr (rd_addr_reg[SLOT_AW-1:0]),
        .rdata (ram_rdata)
    );

    // Pipelined scan: issue one address per cycle, compare the read data in the next cycle
    assign issue = scanning_reg && (rd_addr_reg < count_reg);
    assign match = pend_valid_reg && (ram_rdata == id_reg);

    always_comb
    begin
        scanning_next   = scanning_reg;
        rd_addr_next    = rd_addr_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        scan_done_next  = scan_done_reg;
        scan_hit_next   = scan_hit_reg;
        slot_next       = slot_reg;
        if (cmd.scan_start)
        begin
            scan_done_next  = 1'b0;
            scan_hit_next   = 1'b0;
            pend_valid_next = 1'b0;
            if ({1'b0, id_reg} < FIXED_ID)
            begin
                scanning_next  = 1'b0;
                scan_done_next = 1'b1;
                scan_hit_next  = 1'b1;
                slot_next      = SLOT_AW'(id_reg);
            end
            else
            begin
                scanning_next = 1'b1;
                rd_addr_next  = COUNT_INIT;
            end
        end
        else if (scanning_reg)
        begin
            if (match)
            begin
                scanning_next   = 1'b0;
                pend_valid_next = 1'b0;
                scan_done_next  = 1'b1;
                scan_hit_next   = 1'b1;
                slot_next       = pend_slot_reg;
            end
            else if (!issue && !pend_valid_reg)
            begin
                scanning_next  = 1'b0;
                scan_done_next = 1'b1;
            end
            else
            begin
                pend_valid_next = issue;
                pend_slot_next  = rd_addr_reg[SLOT_AW-1:0];
                if (issue)
                begin
                    rd_addr_next = rd_addr_reg + COUNT_W'(1);
                end
            end
        end
        else if (cmd.append)
        begin
            slot_next = count_reg[SLOT_AW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scanning_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            scan_done_reg  <= 1'b0;
            scan_hit_reg   <= 1'b0;
            count_reg      <= COUNT_INIT;
        end
        else
        begin
            scanning_reg   <= scanning_next;
            pend_valid_reg <= pend_valid_next;
            scan_done_reg  <= scan_done_next;
            scan_hit_reg   <= scan_hit_next;
            if (cmd.append)
            begin
                count_reg <= count_reg + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg   <= rd_addr_next;
        pend_slot_reg <= pend_slot_next;
        slot_reg      <= slot_next;
    end

    // Output register: holds one result until its transfer completes
    assign res_played   = (cmd.res_status == ST_PLAYED);
    assign res_has_slot = res_played || (cmd.res_status == ST_LOADED)
                          || (cmd.res_status == ST_ALREADY);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            out_status_reg <= cmd.res_status;
            out_chan_reg   <= res_played ? CHAN_W'(pick_idx_reg) : '0;
            out_slot_reg   <= res_has_slot ? SLOT_W'(slot_reg) : '0;
            out_vol_reg    <= res_played ? amp_reg : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_user  = out_status_reg;
    assign out_data  = {out_vol_reg, out_slot_reg, out_chan_reg};

    // Status to controller
    assign stat.req_type   = req_type_t'(req_type_reg);
    assign stat.amp_zero   = (amp_reg == '0);
    assign stat.pick_found = first_found;
    assign stat.old_last   = (oc_reg == CH_IW'(CHANNELS - 1));
    assign stat.pick_valid = pick_valid_reg;
    assign stat.scan_done  = scan_done_reg;
    assign stat.scan_hit   = scan_hit_reg;
    assign stat.table_full = (count_reg == COUNT_FULL);
    assign stat.out_stall  = out_valid_reg && !out_ready;

endmodule

### rtl/sound_channel_allocator_core.sv
// Per item: a tick, silent or ignored request goes from decode straight to the output register;
// a play adds the oldest-channel search over all channels when needed, then, if a channel
// was picked, a table lookup, as a load does: a fixed id resolves without the RAM, else appended
// slots are scanned on the RAM read port. Throughput: one item at a time, plus output stalls.
// Reset: asynchronous, clears time and channels and sets the loaded count back to the fixed ids;
// the RAM needs no clearing, fixed ids are implied by slot number and appended slots are read only below the count.
`include "sound_channel_allocator_core_defines.svh"

module sound_channel_allocator_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [9:0] sound_code, [17:10] amplitude, [33:18] persistence, [36:34] priority_req
    input  logic [sca_pkg::IN_DATA_W-1:0]     s_tdata,
    // [1:0] req_type
    input  logic [sca_pkg::IN_USER_W-1:0]     s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [1:0] channel, [7:2] sound_slot, [15:8] volume
    output logic [sca_pkg::OUT_DATA_W-1:0]    m_tdata,
    // [2:0] status
    output logic [sca_pkg::OUT_USER_W-1:0]    m_tuser
);

    import sca_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // Sequencer
    sca_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath
    sca_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_tdata),
        .in_user   (s_tuser),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_user  (m_tuser)
    );

    // Checks
    `SCA_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "item accepted while busy")
    `SCA_ASSERT_SAME(a_result_no_overwrite, cmd.load_result, !(m_tvalid && !m_tready), "result overwritten")
    `SCA_ASSERT_SAME(a_commit_checked, cmd.commit, stat.pick_valid && stat.scan_hit, "bad commit")

endmodule

### bench/sound_channel_allocator_core_tb.sv
// Testbench for sound_channel_allocator_core: directed and random stream traffic,
// scoreboarded against an in-bench model of the channel allocator.
// Depends on sca_pkg and the RTL of the core.
`timescale 1ns / 1ps

module sound_channel_allocator_core_tb;
    import sca_pkg::*;

    localparam int unsigned LIMIT_CYCLES = 1000000;
    localparam int unsigned DRAIN_LIMIT  = 5000;
    localparam int unsigned SETTLE_CYCLES = 100;
    localparam int unsigned MAX_REPORTS  = 10;

    // Request code that the core ignores
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        status_t           status;
        logic [CHAN_W-1:0] channel;
        logic [SLOT_W-1:0] slot;
        logic [AMP_W-1:0]  volume;
    } alloc_result_t;

    // DUT ports
    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [IN_USER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;

    // Model of the allocator state
    logic [TIME_BITS-1:0] now_time;
    logic [ID_W-1:0]      ch_sound [CHANNELS];
    logic                 ch_held  [CHANNELS];
    logic [AMP_W-1:0]     ch_vol   [CHANNELS];
    logic [PRIO_W-1:0]    ch_prio  [CHANNELS];
    logic [TIME_BITS-1:0] ch_until [CHANNELS];
    logic [ID_W-1:0]      table_ids [SOUND_SLOTS];
    int                   table_cnt;

    alloc_result_t pending_results[$];

    // Bookkeeping
    int unsigned cycle_cnt = 0;
    int unsigned fail_cnt = 0;
    int unsigned mismatch_cnt = 0;
    int unsigned n_sent = 0;
    int unsigned n_played = 0;
    int unsigned n_no_chan = 0;
    int unsigned n_not_loaded = 0;
    int unsigned n_full = 0;
    logic        quiet_mode = 1'b0;
    int          rdy_wait = 0;

    sound_channel_allocator_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    // Run-time guard
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, pending_results.size());
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int draw_wait();
        if (quiet_mode)
            return 0;
        return $urandom_range(0, 6);
    endfunction

    // ---------------------------------------------------------------
    // Allocator model
    // ---------------------------------------------------------------
    function automatic void reset_model();
        now_time = '0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            ch_sound[i] = '0;
            ch_held[i]  = 1'b0;
            ch_vol[i]   = '0;
            ch_prio[i]  = '0;
            ch_until[i] = '0;
        end
        for (int s = 0; s < SOUND_SLOTS; s++)
            table_ids[s] = (s < FIXED_SOUNDS) ? ID_W'(s) : '0;
        table_cnt = FIXED_SOUNDS;
    endfunction

    function automatic int find_slot(input logic [ID_W-1:0] id);
        for (int s = 0; s < table_cnt; s++)
            if (table_ids[s] == id)
                return s;
        return -1;
    endfunction

    // Steal order: same sound, quieter, lower priority, furthest past reservation
    function automatic int choose_channel(input logic [ID_W-1:0] id,
                                          input logic [AMP_W-1:0] amp,
                                          input logic [PRIO_W-1:0] prio);
        int                   pick;
        logic [TIME_BITS-1:0] past;
        logic [TIME_BITS-1:0] best;
        pick = -1;
        best = '0;
        if (prio > VERY_LOW_PRIORITY)
            for (int i = 0; i < CHANNELS; i++)
                if (ch_held[i] && ch_sound[i] == id && ch_vol[i] <= amp)
                    return i;
        for (int i = 0; i < CHANNELS; i++)
            if (ch_vol[i] < amp)
                return i;
        for (int i = 0; i < CHANNELS; i++)
            if (ch_prio[i] < prio)
                return i;
        // signed wrap-around age, only strictly positive counts
        for (int i = 0; i < CHANNELS; i++)
        begin
            past = now_time - ch_until[i];
            if (!past[TIME_BITS-1] && past > best)
            begin
                best = past;
                pick = i;
            end
        end
        return pick;
    endfunction

    function automatic alloc_result_t predict_alloc(input logic [REQ_W-1:0] kind,
                                                    input logic [ID_W-1:0] id,
                                                    input logic [AMP_W-1:0] amp,
                                                    input logic [PERS_W-1:0] pers,
                                                    input logic [PRIO_W-1:0] prio);
        alloc_result_t r;
        int            c;
        int            s;
        r = '{status: ST_TICK, channel: '0, slot: '0, volume: '0};
        case (kind)
            REQ_TICK:
                now_time = now_time + 1'b1;
            REQ_PLAY:
                if (amp == '0)
                    r.status = ST_SILENT;
                else
                begin
                    c = choose_channel(id, amp, prio);
                    s = find_slot(id);
                    if (c < 0)
                    begin
                        r.status = ST_NO_CHANNEL;
                        n_no_chan++;
                    end
                    else if (s < 0)
                    begin
                        r.status = ST_NOT_LOADED;
                        n_not_loaded++;
                    end
                    else
                    begin
                        ch_sound[c] = id;
                        ch_held[c]  = 1'b1;
                        ch_until[c] = now_time + TIME_BITS'(pers);
                        ch_prio[c]  = prio;
                        ch_vol[c]   = amp;
                        r.status  = ST_PLAYED;
                        r.channel = CHAN_W'(c);
                        r.slot    = SLOT_W'(s);
                        r.volume  = amp;
                        n_played++;
                    end
                end
            REQ_LOAD:
            begin
                s = find_slot(id);
                if (s >= 0)
                begin
                    r.status = ST_ALREADY;
                    r.slot   = SLOT_W'(s);
                end
                else if (table_cnt >= SOUND_SLOTS)
                begin
                    r.status = ST_FULL;
                    n_full++;
                end
                else
                begin
                    table_ids[table_cnt] = id;
                    r.status = ST_LOADED;
                    r.slot   = SLOT_W'(table_cnt);
                    table_cnt++;
                end
            end
            default: ;  // unused code: no state change
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Input side: one transfer per call, prediction at acceptance
    // ---------------------------------------------------------------
    task automatic send_req(input logic [REQ_W-1:0] kind, input logic [ID_W-1:0] id,
                            input logic [AMP_W-1:0] amp, input logic [PERS_W-1:0] pers,
                            input logic [PRIO_W-1:0] prio);
        int                   gap;
        logic [IN_DATA_W-1:0] d;
        gap = draw_wait();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        d = '0;
        d[ID_LSB +: ID_W]     = id;
        d[AMP_LSB +: AMP_W]   = amp;
        d[PERS_LSB +: PERS_W] = pers;
        d[PRIO_LSB +: PRIO_W] = prio;
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= kind;
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(predict_alloc(kind, id, amp, pers, prio));
        n_sent++;
    endtask

    // ---------------------------------------------------------------
    // Output side: random backpressure and result checking
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        int w;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rdy_wait <= 0;
        end
        else if (m_tvalid && m_tready)
        begin
            w = draw_wait();
            m_tready <= (w == 0);
            rdy_wait <= w;
        end
        else if (!m_tready)
        begin
            if (rdy_wait <= 1)
                m_tready <= 1'b1;
            else
                rdy_wait <= rdy_wait - 1;
        end
    end

    always @(posedge clk)
    begin
        alloc_result_t got;
        alloc_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status  = status_t'(m_tuser);
            got.channel = m_tdata[1:0];
            got.slot    = m_tdata[7:2];
            got.volume  = m_tdata[15:8];
            if (pending_results.size() == 0)
            begin
                fail_cnt++;
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS)
                    $display("Unexpected result: status %0d channel %0d slot %0d volume %0d",
                             got.status, got.channel, got.slot, got.volume);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.channel !== want.channel ||
                    got.slot !== want.slot || got.volume !== want.volume)
                begin
                    fail_cnt++;
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                    begin
                        $display("Mismatch at cycle %0d (expected/actual):", cycle_cnt);
                        $display("  status %0d/%0d chan %0d/%0d slot %0d/%0d vol %0d/%0d",
                                 want.status, got.status, want.channel, got.channel,
                                 want.slot, got.slot, want.volume, got.volume);
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // A tick, ignored code, silent play, not-loaded play and table lookups
    task automatic test_basic_requests();
        send_req(REQ_TICK, 10'h3FF, 8'hFF, 16'hFFFF, 3'd7);
        send_req(REQ_UNUSED, 10'h3FF, 8'hFF, 16'hFFFF, 3'd7);
        send_req(REQ_UNUSED, 10'h000, 8'h00, 16'h0000, 3'd0);
        send_req(REQ_PLAY, 10'd5, 8'h00, 16'h1234, 3'd5);
        send_req(REQ_PLAY, 10'h3FF, 8'hFF, 16'd10, 3'd7);
        send_req(REQ_PLAY, 10'd0, 8'hFF, 16'hFFFF, 3'd7);
        send_req(REQ_PLAY, 10'd13, 8'h01, 16'h0000, 3'd0);
        send_req(REQ_PLAY, 10'd13, 8'h01, 16'd3, 3'd2);
        send_req(REQ_LOAD, 10'd13, 8'h00, 16'h0000, 3'd0);
        send_req(REQ_LOAD, 10'h3FF, 8'hFF, 16'hFFFF, 3'd7);
        send_req(REQ_LOAD, 10'd0, 8'h55, 16'h5555, 3'd5);
        send_req(REQ_PLAY, 10'h3FF, 8'h80, 16'd1, 3'd6);
    endtask

    // Fill every channel loud and high, then exercise no-channel and oldest-channel steals
    task automatic test_channel_steal();
        send_req(REQ_PLAY, 10'd1, 8'hFF, 16'd0, 3'd7);
        send_req(REQ_PLAY, 10'd2, 8'hFF, 16'd0, 3'd7);
        send_req(REQ_PLAY, 10'd3, 8'hFF, 16'd2, 3'd7);
        send_req(REQ_PLAY, 10'd4, 8'hFF, 16'd0, 3'd7);
        send_req(REQ_TICK, 10'd0, 8'd0, 16'd0, 3'd0);
        send_req(REQ_TICK, 10'd0, 8'd0, 16'd0, 3'd0);
        send_req(REQ_PLAY, 10'd4, 8'hFF, 16'd0, 3'd7);
        send_req(REQ_PLAY, 10'd4, 8'hFF, 16'd5, 3'd2);
        send_req(REQ_PLAY, 10'd4, 8'hC8, 16'd5, 3'd1);
        send_req(REQ_PLAY, 10'd9, 8'h80, 16'hFFFF, 3'd6);
        send_req(REQ_PLAY, 10'd8, 8'h01, 16'd0, 3'd0);
        send_req(REQ_TICK, 10'd0, 8'd0, 16'd0, 3'd0);
        send_req(REQ_PLAY, 10'd8, 8'hFF, 16'd7, 3'd7);
    endtask

    // Mostly well-formed traffic with random content; loads tend to fill the table
    task automatic test_random_traffic(input int n_items);
        int                sel;
        logic [REQ_W-1:0]  kind;
        logic [ID_W-1:0]   id;
        logic [AMP_W-1:0]  amp;
        logic [PERS_W-1:0] pers;
        logic [PRIO_W-1:0] prio;
        for (int k = 0; k < n_items; k++)
        begin
            if (k % 100 == 0)
                quiet_mode <= ($urandom_range(0, 2) == 0);
            sel  = $urandom_range(0, 99);
            id   = ID_W'($urandom);
            amp  = AMP_W'($urandom);
            pers = PERS_W'($urandom);
            prio = PRIO_W'($urandom);
            if (sel < 35)
                kind = REQ_TICK;
            else if (sel < 75)
            begin
                kind = REQ_PLAY;
                if ($urandom_range(0, 9) < 7)
                    id = table_ids[$urandom_range(0, table_cnt - 1)];
                case ($urandom_range(0, 9))
                    0:       amp = '0;
                    1, 2, 3: amp = '1;
                    default: ;
                endcase
                if ($urandom_range(0, 9) < 7)
                    pers = PERS_W'($urandom_range(0, 15));
            end
            else if (sel < 92)
            begin
                kind = REQ_LOAD;
                if ($urandom_range(0, 9) < 3)
                    id = table_ids[$urandom_range(0, table_cnt - 1)];
            end
            else
                kind = REQ_UNUSED;
            send_req(kind, id, amp, pers, prio);
        end
        quiet_mode <= 1'b0;
    endtask

    // Top off the table, then hit the full case and a lookup in the last slot
    task automatic test_table_full();
        logic [ID_W-1:0] id;
        while (table_cnt < SOUND_SLOTS)
        begin
            do
                id = ID_W'($urandom);
            while (find_slot(id) >= 0);
            send_req(REQ_LOAD, id, 8'd0, 16'd0, 3'd0);
        end
        do
            id = ID_W'($urandom);
        while (find_slot(id) >= 0);
        send_req(REQ_LOAD, id, 8'hFF, 16'hFFFF, 3'd7);
        send_req(REQ_LOAD, table_ids[SOUND_SLOTS-1], 8'd0, 16'd0, 3'd0);
        send_req(REQ_PLAY, table_ids[SOUND_SLOTS-1], 8'hFF, 16'd3, 3'd7);
        send_req(REQ_PLAY, id, 8'hFF, 16'd3, 3'd7);
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial
    begin
        int unsigned waited;
        reset_model();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_requests();
        test_channel_steal();
        test_random_traffic(650);
        test_table_full();
        test_random_traffic(650);

        // let the last results drain
        @(posedge clk);
        s_tvalid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $display("%0d results never arrived", pending_results.size());
            fail_cnt += pending_results.size();
        end

        $display("Sent %0d requests: %0d plays started, %0d without a channel, %0d not loaded",
                 n_sent, n_played, n_no_chan, n_not_loaded);
        $display("Table reached %0d entries, %0d loads refused as full; %0d mismatches",
                 table_cnt, n_full, mismatch_cnt);
        if (fail_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/sca_pkg.sv
rtl/sca_ram.sv
rtl/sca_ctrl.sv
rtl/sca_datapath.sv
rtl/sound_channel_allocator_core.sv
bench/sound_channel_allocator_core_tb.sv
